// ===== hdl/palette_indexed_led_packet_decoder_core_assert.svh =====
// assertion macros shared by the palette decoder modules
// expects signals named clock and reset in the module that uses them
`ifndef PALETTE_INDEXED_LED_PACKET_DECODER_CORE_ASSERT_SVH
`define PALETTE_INDEXED_LED_PACKET_DECODER_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define PILD_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define PILD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/pild_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the palette-indexed led packet decoder
// no dependencies
package pild_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;
   localparam logic [8:0] MAX_LEDS = 9'd256;
   localparam logic [7:0] OPCODE_PALETTE = 8'h01;
   localparam logic [8:0] LED_COUNT_RESET = 9'd100;
   localparam int RSP_QUEUE_DEPTH = 4;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_COMMIT = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } result_type;

   // registered decode outcome, aligned with the palette read data
   typedef struct packed {
      logic       pix;
      logic       commit;
      logic [7:0] led_index;
   } stage_type;

endpackage

// ===== hdl/pild_req_if.sv =====
`timescale 1ns / 1ps
// packet byte channel with valid/ready handshake
// no dependencies
interface pild_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       packet_end;

   modport source (output valid, output packet_byte, output packet_end, input ready);
   modport sink (input valid, input packet_byte, input packet_end, output ready);
endinterface

// ===== hdl/pild_rsp_if.sv =====
`timescale 1ns / 1ps
// result channel with valid/ready handshake
// no dependencies
interface pild_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] led_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output result_kind, output led_index, output red,
                   output green, output blue, input ready);
   modport sink (input valid, input result_kind, input led_index, input red,
                 input green, input blue, output ready);
endinterface

// ===== hdl/pild_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module pild_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pild_parser.sv =====
`timescale 1ns / 1ps
// packet header/palette/index byte decoder, drives palette ram and stage register
// depends on pild_pkg and palette_indexed_led_packet_decoder_core_assert.svh
`include "palette_indexed_led_packet_decoder_core_assert.svh"
module pild_parser #(
   parameter int PALETTE_DEPTH = pild_pkg::PALETTE_DEPTH_DEF,
   localparam int AddrWidth = $clog2(PALETTE_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_accept,
   input  logic [7:0]            in_byte,
   input  logic                  in_end,
   input  logic [8:0]            strip_len,
   output logic                  ram_wr_en,
   output logic [AddrWidth-1:0]  ram_wr_addr,
   output logic [23:0]           ram_wr_data,
   output logic                  ram_rd_en,
   output logic [AddrWidth-1:0]  ram_rd_addr,
   output pild_pkg::stage_type   stage
);

   typedef enum logic [1:0] {
      HDR_OPCODE,
      HDR_PAL_LEN,
      HDR_DATA_LEN,
      BODY
   } hdr_state_type;

   localparam logic [8:0] DepthLimit = 9'(PALETTE_DEPTH);

   hdr_state_type       hdr_ff, hdr_in;
   logic [7:0]          opcode_ff, opcode_in;
   logic [7:0]          pal_len_ff, pal_len_in;
   logic [7:0]          data_len_ff, data_len_in;
   logic [1:0]          phase_ff, phase_in;
   logic [7:0]          entry_ff, entry_in;
   logic [7:0]          k_ff, k_in;
   logic [15:0]         partial_ff, partial_in;
   pild_pkg::stage_type stage_ff, stage_in;

   logic [7:0] data_len_now;
   logic       hdr_ok;
   logic       pix;
   logic       commit;

   always_comb begin
      hdr_in      = hdr_ff;
      opcode_in   = opcode_ff;
      pal_len_in  = pal_len_ff;
      data_len_in = data_len_ff;
      phase_in    = phase_ff;
      entry_in    = entry_ff;
      k_in        = k_ff;
      partial_in  = partial_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = entry_ff[AddrWidth-1:0];
      ram_wr_data = {partial_ff, in_byte};
      ram_rd_en   = 1'b0;
      ram_rd_addr = in_byte[AddrWidth-1:0];
      pix         = 1'b0;
      commit      = 1'b0;

      // data length byte counts toward validity on the beat that carries it
      data_len_now = (hdr_ff == HDR_DATA_LEN) ? in_byte : data_len_ff;
      hdr_ok = (opcode_ff == pild_pkg::OPCODE_PALETTE) && (pal_len_ff <= data_len_now);

      if (in_accept) begin
         unique case (hdr_ff)
            HDR_OPCODE: begin
               opcode_in = in_byte;
               hdr_in    = HDR_PAL_LEN;
            end
            HDR_PAL_LEN: begin
               pal_len_in = in_byte;
               hdr_in     = HDR_DATA_LEN;
            end
            HDR_DATA_LEN: begin
               data_len_in = in_byte;
               hdr_in      = BODY;
            end
            BODY: begin
               if (hdr_ok) begin
                  if (entry_ff < pal_len_ff) begin
                     case (phase_ff)
                        2'd0: begin
                           partial_in = {in_byte, 8'h00};
                           phase_in   = 2'd1;
                        end
                        2'd1: begin
                           partial_in = {partial_ff[15:8], in_byte};
                           phase_in   = 2'd2;
                        end
                        default: begin
                           ram_wr_en = ({1'b0, entry_ff} < DepthLimit);
                           entry_in  = entry_ff + 8'd1;
                           phase_in  = 2'd0;
                        end
                     endcase
                  end else if (k_ff < data_len_ff) begin
                     pix = ({1'b0, k_ff} < strip_len) && ({1'b0, k_ff} < pild_pkg::MAX_LEDS)
                        && (in_byte < pal_len_ff) && ({1'b0, in_byte} < DepthLimit);
                     ram_rd_en = pix;
                     k_in      = k_ff + 8'd1;
                  end
               end
            end
         endcase

         commit = in_end && hdr_ok && ((hdr_ff == HDR_DATA_LEN) || (hdr_ff == BODY));

         if (in_end) begin
            hdr_in   = HDR_OPCODE;
            phase_in = 2'd0;
            entry_in = 8'd0;
            k_in     = 8'd0;
         end
      end

      stage_in.pix       = pix;
      stage_in.commit    = commit;
      stage_in.led_index = k_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff          <= HDR_OPCODE;
         opcode_ff       <= 8'd0;
         pal_len_ff      <= 8'd0;
         data_len_ff     <= 8'd0;
         phase_ff        <= 2'd0;
         entry_ff        <= 8'd0;
         k_ff            <= 8'd0;
         partial_ff      <= 16'd0;
         stage_ff.pix    <= 1'b0;
         stage_ff.commit <= 1'b0;
      end else begin
         hdr_ff          <= hdr_in;
         opcode_ff       <= opcode_in;
         pal_len_ff      <= pal_len_in;
         data_len_ff     <= data_len_in;
         phase_ff        <= phase_in;
         entry_ff        <= entry_in;
         k_ff            <= k_in;
         partial_ff      <= partial_in;
         stage_ff.pix    <= stage_in.pix;
         stage_ff.commit <= stage_in.commit;
      end
      stage_ff.led_index <= stage_in.led_index;
   end

   assign stage = stage_ff;

   // palette load and index lookup are separate phases of a packet
   `PILD_ASSERT_ALWAYS(a_no_wr_rd_clash, !(ram_wr_en && ram_rd_en), "palette write and read together")
   `PILD_ASSERT_ALWAYS(a_commit_after_end, !stage_ff.commit || $past(in_accept && in_end), "commit without end beat")
   `PILD_ASSERT_ALWAYS(a_pix_in_body, !ram_rd_en || (hdr_ff == BODY), "pixel lookup outside body")

endmodule

// ===== hdl/pild_rsp_queue.sv =====
`timescale 1ns / 1ps
// small result queue: takes up to two results per cycle, hands out one per beat
// depends on pild_pkg, pild_rsp_if and palette_indexed_led_packet_decoder_core_assert.svh
`include "palette_indexed_led_packet_decoder_core_assert.svh"
module pild_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  pild_pkg::stage_type stage,
   input  logic [23:0]         pix_rgb,
   output logic                can_accept,
   pild_rsp_if.source          rsp
);

   localparam int Depth = pild_pkg::RSP_QUEUE_DEPTH;
   localparam int PtrWidth = $clog2(Depth);
   localparam int CntWidth = $clog2(Depth + 1);

   pild_pkg::result_type mem_ff [Depth];
   logic [PtrWidth-1:0]  wp_ff, wp_in;
   logic [PtrWidth-1:0]  rp_ff, rp_in;
   logic [CntWidth-1:0]  count_ff, count_in;

   pild_pkg::result_type pix_res;
   pild_pkg::result_type commit_res;
   pild_pkg::result_type head;
   logic [1:0]           n_push;
   logic                 pop;

   always_comb begin
      pix_res.kind       = pild_pkg::KIND_PIXEL;
      pix_res.led_index  = stage.led_index;
      pix_res.red        = pix_rgb[23:16];
      pix_res.green      = pix_rgb[15:8];
      pix_res.blue       = pix_rgb[7:0];
      commit_res.kind      = pild_pkg::KIND_COMMIT;
      commit_res.led_index = 8'd0;
      commit_res.red       = 8'd0;
      commit_res.green     = 8'd0;
      commit_res.blue      = 8'd0;

      n_push   = {1'b0, stage.pix} + {1'b0, stage.commit};
      pop      = rsp.valid && rsp.ready;
      wp_in    = wp_ff + PtrWidth'(n_push);
      rp_in    = rp_ff + PtrWidth'(pop);
      count_in = count_ff + CntWidth'(n_push) - CntWidth'(pop);
   end

   // room for the two results the next accepted beat may cause
   assign can_accept = (count_ff + CntWidth'(n_push)) <= CntWidth'(Depth - 2);

   always_ff @(posedge clock) begin
      if (stage.pix) begin
         mem_ff[wp_ff] <= pix_res;
      end
      if (stage.commit) begin
         mem_ff[wp_ff + PtrWidth'(stage.pix)] <= commit_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   assign head            = mem_ff[rp_ff];
   assign rsp.valid       = (count_ff != '0);
   assign rsp.result_kind = head.kind;
   assign rsp.led_index   = head.led_index;
   assign rsp.red         = head.red;
   assign rsp.green       = head.green;
   assign rsp.blue        = head.blue;

   `PILD_ASSERT_ALWAYS(a_count_bound, count_ff <= CntWidth'(Depth), "result queue overflow")
   `PILD_ASSERT_ALWAYS(a_ptr_gap, (wp_ff - rp_ff) == count_ff[PtrWidth-1:0], "queue pointers disagree with count")
   `PILD_ASSERT_NEXT(a_drain, (count_ff == CntWidth'(1)) && pop && (n_push == 2'd0), !rsp.valid, "queue not empty after last beat")

endmodule

// ===== hdl/palette_indexed_led_packet_decoder_core.sv =====
`timescale 1ns / 1ps
// A result passes through the stage and palette read registers and then the result queue
// before it is offered on the result channel.
// Throughput: one packet byte per cycle; a byte that yields both a pixel and a commit pushes
// two results into the four-entry queue and can hold off the next byte while they drain.
// Reset (synchronous, active high) returns the decoder to the header state, empties the
// result queue and sets the strip length to 100; palette contents are left as they were.
module palette_indexed_led_packet_decoder_core #(
   parameter int PALETTE_DEPTH = pild_pkg::PALETTE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pild_req_if.sink   req_bus,
   pild_rsp_if.source rsp_bus,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);

   localparam int AddrWidth = $clog2(PALETTE_DEPTH);

   logic [8:0]           strip_len_ff;
   logic                 can_accept;
   logic                 in_accept;
   logic                 ram_wr_en;
   logic [AddrWidth-1:0] ram_wr_addr;
   logic [23:0]          ram_wr_data;
   logic                 ram_rd_en;
   logic [AddrWidth-1:0] ram_rd_addr;
   logic [23:0]          ram_rd_data;
   pild_pkg::stage_type  stage;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_len_ff <= pild_pkg::LED_COUNT_RESET;
      end else if (csr_wr_en) begin
         strip_len_ff <= csr_wr_data;
      end
   end

   assign req_bus.ready = can_accept;
   assign in_accept     = req_bus.valid && can_accept;

   pild_parser #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (in_accept),
      .in_byte     (req_bus.packet_byte),
      .in_end      (req_bus.packet_end),
      .strip_len   (strip_len_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .stage       (stage)
   );

   pild_ram #(
      .WIDTH(24),
      .DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pild_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .pix_rgb    (ram_rd_data),
      .can_accept (can_accept),
      .rsp        (rsp_bus)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for palette_indexed_led_packet_decoder_core: drives packet bytes,
// predicts pixel writes and frame commits, and checks every result beat in order
// depends on pild_pkg, pild_req_if, pild_rsp_if and the decoder core
module tb_top;

   localparam int HEADER_LEN = 3;
   localparam int POSITION_MAX = 2047;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_BEATS = 600;
   localparam int PHASES = 8;
   localparam int LONG_PAL = 48;

   // keeps its own copy of the decoder state and the led writes it still owes
   class led_write_scoreboard;
      logic [10:0] byte_pos;
      logic [7:0]  opcode;
      logic [7:0]  pal_len;
      logic [7:0]  data_len;
      logic [15:0] red_green;
      logic [23:0] palette [256];
      logic [8:0]  strip_len;
      pild_pkg::result_type owed_writes[$];
      int          mismatches;
      int          pixel_count;
      int          commit_count;

      function new();
         byte_pos = '0;
         opcode = '0;
         pal_len = '0;
         data_len = '0;
         red_green = '0;
         strip_len = pild_pkg::LED_COUNT_RESET;
         mismatches = 0;
         pixel_count = 0;
         commit_count = 0;
      endfunction

      function bit header_ok();
         return opcode == pild_pkg::OPCODE_PALETTE && pal_len <= data_len;
      endfunction

      function void decode_byte(logic [7:0] b, logic last);
         int unsigned pos;
         int unsigned pal_end;
         int unsigned limit;
         int unsigned slot;
         pild_pkg::result_type r;
         pos = byte_pos;
         if (pos == 0) begin
            opcode = b;
         end else if (pos == 1) begin
            pal_len = b;
         end else if (pos == 2) begin
            data_len = b;
         end else if (header_ok()) begin
            pal_end = HEADER_LEN + 3 * pal_len;
            if (pos < pal_end) begin
               slot = (pos - HEADER_LEN) / 3;
               case ((pos - HEADER_LEN) % 3)
                  0: red_green = {b, 8'h00};
                  1: red_green[7:0] = b;
                  default: palette[slot] = {red_green, b};
               endcase
            end else if (pos - pal_end < data_len) begin
               limit = (strip_len < pild_pkg::MAX_LEDS) ? strip_len : pild_pkg::MAX_LEDS;
               // index bytes past the attached leds or past the palette are dropped
               if (pos - pal_end < limit && b < pal_len) begin
                  r.kind = pild_pkg::KIND_PIXEL;
                  r.led_index = 8'(pos - pal_end);
                  {r.red, r.green, r.blue} = palette[b];
                  owed_writes.push_back(r);
               end
            end
         end
         if (last) begin
            if (pos >= 2 && header_ok()) begin
               r = '0;
               r.kind = pild_pkg::KIND_COMMIT;
               owed_writes.push_back(r);
            end
            byte_pos = '0;
         end else if (pos < POSITION_MAX) begin
            byte_pos = 11'(pos + 1);
         end
      endfunction

      function void check_led_write(pild_pkg::result_type got);
         pild_pkg::result_type want;
         if (owed_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: kind %0d led %0d rgb %h%h%h",
                        got.kind, got.led_index, got.red, got.green, got.blue);
            return;
         end
         want = owed_writes.pop_front();
         if (got.kind !== want.kind || got.led_index !== want.led_index ||
             got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result mismatch: expected kind %0d led %0d rgb %h%h%h, ",
                         "got kind %0d led %0d rgb %h%h%h"},
                        want.kind, want.led_index, want.red, want.green, want.blue,
                        got.kind, got.led_index, got.red, got.green, got.blue);
         end else if (got.kind == pild_pkg::KIND_COMMIT) begin
            commit_count++;
         end else begin
            pixel_count++;
         end
      endfunction

      function int pending();
         return owed_writes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [8:0] csr_wr_data;
   bit   idle_on;
   int   quiet_cycles;
   int   random_beats;
   int   total_beats;
   int   settings_used;

   pild_req_if req_bus();
   pild_rsp_if rsp_bus();

   led_write_scoreboard sb = new();

   palette_indexed_led_packet_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // result side back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= !(idle_on && $urandom_range(99) < 11);
   end

   // note every accepted packet beat before checking the result beat of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.decode_byte(req_bus.packet_byte, req_bus.packet_end);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_led_write({rsp_bus.result_kind, rsp_bus.led_index,
                                rsp_bus.red, rsp_bus.green, rsp_bus.blue});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_packet_byte(input logic [7:0] b, input logic last);
      while (idle_on && $urandom_range(99) < 11) begin
         req_bus.valid <= 1'b0;
         req_bus.packet_byte <= 8'($urandom);
         req_bus.packet_end <= 1'($urandom);
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.packet_byte <= b;
      req_bus.packet_end <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      total_beats++;
   endtask

   task automatic send_packet(input logic [7:0] frame[$]);
      foreach (frame[i])
         send_packet_byte(frame[i], i == frame.size() - 1);
   endtask

   // the extra edge lets the monitor note the last beat before the owed count is read
   task automatic wait_frames_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_strip_len(input logic [8:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      sb.strip_len = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic send_random_packet();
      logic [7:0] frame[$];
      int unsigned pick;
      int unsigned pal;
      int unsigned dlen;
      int unsigned cut;
      pick = $urandom_range(99);
      if (pick < 80) begin
         pal = ($urandom_range(15) == 0) ? $urandom_range(48) : $urandom_range(6);
         dlen = pal + $urandom_range(14);
         if (dlen > 255) dlen = 255;
         frame = {pild_pkg::OPCODE_PALETTE, 8'(pal), 8'(dlen)};
         repeat (3 * pal) frame.push_back(8'($urandom));
         repeat (dlen) begin
            if (pal == 0 || $urandom_range(9) == 0) frame.push_back(8'($urandom));
            else frame.push_back(8'($urandom_range(pal - 1)));
         end
         if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 5)) frame.push_back(8'($urandom));
         // truncated packet: the end flag lands early
         if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut) void'(frame.pop_back());
         end
      end else if (pick < 87) begin
         frame = {8'($urandom_range(1))};
         if ($urandom_range(1)) frame.push_back(8'($urandom));
      end else if (pick < 94) begin
         frame = {8'($urandom)};
         if (frame[0] == pild_pkg::OPCODE_PALETTE) frame[0] = 8'h00;
         repeat ($urandom_range(2, 12)) frame.push_back(8'($urandom));
      end else begin
         // palette length above data length
         pal = $urandom_range(1, 255);
         frame = {pild_pkg::OPCODE_PALETTE, 8'(pal), 8'($urandom_range(pal - 1))};
         repeat ($urandom_range(9)) frame.push_back(8'($urandom));
      end
      send_packet(frame);
      random_beats += frame.size();
   endtask

   // mid-size palette, every led position up to 254, then a few trailing bytes
   task automatic send_long_packet();
      logic [7:0] frame[$];
      int unsigned roll;
      frame = {pild_pkg::OPCODE_PALETTE, 8'(LONG_PAL), 8'd255};
      repeat (3 * LONG_PAL) frame.push_back(8'($urandom));
      repeat (255) begin
         roll = $urandom_range(19);
         if (roll == 0) frame.push_back(8'hFF);
         else if (roll == 1) frame.push_back(8'(LONG_PAL));
         else frame.push_back(8'($urandom_range(LONG_PAL - 1)));
      end
      repeat (8) frame.push_back(8'($urandom));
      send_packet(frame);
   endtask

   initial begin
      logic [7:0] frame[$];
      logic [8:0] settings [PHASES];
      int target;
      settings = '{9'd1, 9'd256, 9'd3, 9'd511, 9'd0, 9'd256, 9'd255, 9'd100};
      settings[5] = 9'($urandom_range(1, 256));
      idle_on = 1'b1;
      total_beats = 0;
      random_beats = 0;
      settings_used = 1;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.packet_byte <= '0;
      req_bus.packet_end <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short packets, an empty valid frame, a bad opcode, palette longer than data
      frame = {8'h01};
      send_packet(frame);
      frame = {8'h01, 8'h00};
      send_packet(frame);
      frame = {pild_pkg::OPCODE_PALETTE, 8'h00, 8'h00};
      send_packet(frame);
      frame = {8'hFF, 8'h00, 8'h00};
      send_packet(frame);
      frame = {pild_pkg::OPCODE_PALETTE, 8'hFF, 8'hFE};
      send_packet(frame);
      // two entries, an out-of-range index, then a trailing byte
      frame = {pild_pkg::OPCODE_PALETTE, 8'h02, 8'h03, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
               8'h00, 8'h01, 8'hFF, 8'h00, 8'h00};
      send_packet(frame);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_frames_drained();
         write_strip_len(settings[ph]);
         idle_on = (ph != 2);
         if (ph == 1) send_long_packet();
         target = RANDOM_BEATS * (ph + 1) / PHASES;
         while (random_beats < target) begin
            send_random_packet();
            if ($urandom_range(24) == 0) wait_frames_drained();
         end
      end
      idle_on = 1'b1;

      wait_frames_drained();
      repeat (8) @(posedge clock);
      $display("sent %0d packet beats under %0d strip length settings", total_beats,
               settings_used);
      $display("checked %0d pixel writes and %0d frame commits, %0d mismatches",
               sb.pixel_count, sb.commit_count, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
